>>> hdl/assert_macros.svh
// assertion macros shared by the spectral tone detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/stdet_pkg.sv
// types, constants and register codes of the spectral tone detector
package stdet_pkg;

  // spectrum geometry
  localparam int NUM_BINS = 1024;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int IDX_W    = BIN_W + 1;
  localparam int HALF     = NUM_BINS / 2;

  // field widths
  localparam int MAG_W      = 32;
  localparam int PEAK_OUT_W = 10;
  localparam int FREQ_W     = 17;
  localparam int CODE_W     = 3;
  localparam int CNT_W      = 8;
  localparam int HZ_W       = 13;
  localparam int TOL_W      = 8;
  localparam int CFG_DATA_W = HZ_W;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_BANDS  = 4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BAND_ONE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BAND_TWO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BAND_THREE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BAND_FOUR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;

  // register reset values
  localparam logic [HZ_W-1:0]  BAND_ONE_RST   = 13'd550;
  localparam logic [HZ_W-1:0]  BAND_TWO_RST   = 13'd620;
  localparam logic [HZ_W-1:0]  BAND_THREE_RST = 13'd666;
  localparam logic [HZ_W-1:0]  BAND_FOUR_RST  = 13'd697;
  localparam logic [TOL_W-1:0] TOL_RST        = 8'd3;
  localparam logic [CNT_W-1:0] THRESH_RST     = 8'd50;

  // line through bin 513 at 7800 Hz and bin 1004 at 300 Hz, scaled by 491
  localparam int NUM_C    = 122836800;
  localparam int NUM_RND  = NUM_C + 245;
  localparam int SLOPE    = 120000;
  localparam int SLOPE_W  = 17;
  localparam int DIV      = 491;
  localparam int DIV_W    = 9;
  localparam int X_W      = 27;
  localparam int PROD_W   = SLOPE_W + BIN_W;
  localparam int WIDE_W   = (PROD_W > X_W) ? PROD_W : X_W;
  localparam int RECIP_SH = 28;
  localparam int RECIP    = (1 << RECIP_SH) / DIV;
  localparam int RECIP_W  = 20;
  localparam int Q_W      = 19;
  localparam int R_W      = Q_W + DIV_W;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // band compare width: signed 16 * (centre +- tolerance)
  localparam int CMP_W = HZ_W + 4 + 2;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  typedef struct packed {
    logic [BIN_W-1:0]  peak;
    logic [FREQ_W-1:0] freq;
  } freq_item_t;

  typedef struct packed {
    logic [NUM_BANDS-1:0][HZ_W-1:0] band_hz;
    logic [TOL_W-1:0]               tol_hz;
    logic [CNT_W-1:0]               thresh;
  } cfg_t;

endpackage

>>> hdl/stdet_if.sv
// valid/ready channel interfaces for bins in and detection results out
interface stdet_in_if;
  logic                       valid;
  logic                       ready;
  logic [stdet_pkg::MAG_W-1:0] bin_magnitude;
  logic                       frame_end;

  modport source (output valid, output bin_magnitude, output frame_end, input ready);
  modport sink (input valid, input bin_magnitude, input frame_end, output ready);
endinterface

interface stdet_out_if;
  logic                             valid;
  logic                             ready;
  logic [stdet_pkg::PEAK_OUT_W-1:0] peak_bin;
  logic [stdet_pkg::FREQ_W-1:0]     peak_freq_q4;
  logic [stdet_pkg::CODE_W-1:0]     tone_code;
  logic [stdet_pkg::CNT_W-1:0]      repeat_count;
  logic                             detected;

  modport source (output valid, output peak_bin, output peak_freq_q4, output tone_code,
                  output repeat_count, output detected, input ready);
  modport sink (input valid, input peak_bin, input peak_freq_q4, input tone_code,
                input repeat_count, input detected, output ready);
endinterface

>>> hdl/stdet_peak_search.sv
// running peak search over the upper half of each spectrum frame
`include "assert_macros.svh"

module stdet_peak_search (
  input  logic                       clk,
  input  logic                       rst_n,
  stdet_in_if.sink                   in_ch,
  output logic                       pk_valid,
  input  logic                       pk_ready,
  output logic [stdet_pkg::BIN_W-1:0] pk_bin
);

  logic [stdet_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [stdet_pkg::MAG_W-1:0] best_r, best_nxt, cur_best;
  logic [stdet_pkg::BIN_W-1:0] best_bin_r, best_bin_nxt, cur_bin;
  logic [stdet_pkg::BIN_W-1:0] pk_bin_r;
  logic                        pk_valid_r, pk_valid_nxt;
  logic                        in_acc, upper, take;

  assign in_ch.ready = !pk_valid_r || pk_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // compare the incoming beat against the best so far
  always_comb begin
    upper = (idx_r >= stdet_pkg::IDX_W'(stdet_pkg::HALF)) &&
            (idx_r <  stdet_pkg::IDX_W'(stdet_pkg::NUM_BINS));
    take     = upper && (in_ch.bin_magnitude > best_r);
    cur_best = take ? in_ch.bin_magnitude : best_r;
    cur_bin  = take ? idx_r[stdet_pkg::BIN_W-1:0] : best_bin_r;
  end

  // frame state update, cleared on the last beat of a frame
  always_comb begin
    idx_nxt      = idx_r;
    best_nxt     = best_r;
    best_bin_nxt = best_bin_r;
    pk_valid_nxt = pk_valid_r && !pk_ready;
    if (in_acc) begin
      if (in_ch.frame_end) begin
        idx_nxt      = '0;
        best_nxt     = '0;
        best_bin_nxt = stdet_pkg::BIN_W'(stdet_pkg::HALF);
        pk_valid_nxt = 1'b1;
      end else begin
        idx_nxt      = (idx_r == stdet_pkg::IDX_W'(stdet_pkg::NUM_BINS)) ? idx_r :
                       idx_r + 1'b1;
        best_nxt     = cur_best;
        best_bin_nxt = cur_bin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      best_r     <= '0;
      best_bin_r <= stdet_pkg::BIN_W'(stdet_pkg::HALF);
      pk_valid_r <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      best_r     <= best_nxt;
      best_bin_r <= best_bin_nxt;
      pk_valid_r <= pk_valid_nxt;
    end
  end

  // peak of the finished frame
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.frame_end) begin
      pk_bin_r <= cur_bin;
    end
  end

  assign pk_valid = pk_valid_r;
  assign pk_bin   = pk_bin_r;

  `ASSERT_ALWAYS(a_best_upper, best_bin_r >= stdet_pkg::BIN_W'(stdet_pkg::HALF), "best bin left the upper half")
  `ASSERT_NEXT(a_frame_clear, in_acc && in_ch.frame_end, idx_r == '0 && best_r == '0, "frame state not cleared after frame end")

endmodule

>>> hdl/stdet_freq_map.sv
// three stage linear map from peak bin to q4 frequency with rounding
module stdet_freq_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pk_valid,
  output logic                        pk_ready,
  input  logic [stdet_pkg::BIN_W-1:0] pk_bin,
  output logic                        fr_valid,
  input  logic                        fr_ready,
  output stdet_pkg::freq_item_t       fr_item
);

  // stage b: offset minus slope times bin
  logic                          b_v_r;
  logic                          b_neg_r;
  logic [stdet_pkg::X_W-1:0]     b_x_r;
  logic [stdet_pkg::BIN_W-1:0]   b_peak_r;
  // stage c: reciprocal quotient estimate
  logic                          c_v_r;
  logic                          c_neg_r;
  logic [stdet_pkg::X_W-1:0]     c_x_r;
  logic [stdet_pkg::Q_W-1:0]     c_q_r;
  logic [stdet_pkg::BIN_W-1:0]   c_peak_r;
  // stage d: corrected and saturated frequency
  logic                          d_v_r;
  stdet_pkg::freq_item_t         d_item_r;

  logic                          b_ready, c_ready, d_ready;
  logic [stdet_pkg::WIDE_W-1:0]  prod_w;
  logic                          neg;
  logic [stdet_pkg::X_W-1:0]     x_val;
  logic [stdet_pkg::X_W+stdet_pkg::RECIP_W-1:0] qprod;
  logic [stdet_pkg::R_W-1:0]     qdiv, rem;
  logic [stdet_pkg::Q_W-1:0]     q_fix;
  logic [stdet_pkg::FREQ_W-1:0]  freq;

  // bubble-collapsing stage handshakes
  assign d_ready  = !d_v_r || fr_ready;
  assign c_ready  = !c_v_r || d_ready;
  assign b_ready  = !b_v_r || c_ready;
  assign pk_ready = b_ready;

  // numerator, with a flag for bins past the zero crossing
  always_comb begin
    prod_w = stdet_pkg::WIDE_W'(stdet_pkg::PROD_W'(stdet_pkg::SLOPE_W'(stdet_pkg::SLOPE) * pk_bin));
    neg    = prod_w > stdet_pkg::WIDE_W'(stdet_pkg::NUM_C);
    x_val  = stdet_pkg::X_W'(stdet_pkg::WIDE_W'(stdet_pkg::NUM_RND) - prod_w);
  end

  // quotient estimate, low by at most one
  assign qprod = stdet_pkg::X_W'(b_x_r) * stdet_pkg::RECIP_W'(stdet_pkg::RECIP);

  // remainder check and saturation
  always_comb begin
    qdiv  = stdet_pkg::R_W'(c_q_r * stdet_pkg::DIV_W'(stdet_pkg::DIV));
    rem   = stdet_pkg::R_W'(c_x_r) - qdiv;
    q_fix = (rem >= stdet_pkg::R_W'(stdet_pkg::DIV)) ? c_q_r + 1'b1 : c_q_r;
    if (c_neg_r) begin
      freq = '0;
    end else if (q_fix > stdet_pkg::Q_W'(stdet_pkg::FREQ_MAX)) begin
      freq = stdet_pkg::FREQ_MAX;
    end else begin
      freq = q_fix[stdet_pkg::FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_v_r <= pk_valid;
      end
      if (c_ready) begin
        c_v_r <= b_v_r;
      end
      if (d_ready) begin
        d_v_r <= c_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (b_ready && pk_valid) begin
      b_neg_r  <= neg;
      b_x_r    <= x_val;
      b_peak_r <= pk_bin;
    end
    if (c_ready && b_v_r) begin
      c_neg_r  <= b_neg_r;
      c_x_r    <= b_x_r;
      c_q_r    <= qprod[stdet_pkg::RECIP_SH +: stdet_pkg::Q_W];
      c_peak_r <= b_peak_r;
    end
    if (d_ready && c_v_r) begin
      d_item_r.peak <= c_peak_r;
      d_item_r.freq <= freq;
    end
  end

  assign fr_valid = d_v_r;
  assign fr_item  = d_item_r;

endmodule

>>> hdl/stdet_tone_class.sv
// band classification, persistence count and result register
`include "assert_macros.svh"

module stdet_tone_class (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fr_valid,
  output logic                  fr_ready,
  input  stdet_pkg::freq_item_t fr_item,
  input  stdet_pkg::cfg_t       cfg,
  stdet_out_if.source           out_ch
);

  logic                              e_v_r;
  logic [stdet_pkg::CODE_W-1:0]      e_code_r;
  stdet_pkg::freq_item_t             e_item_r;
  logic                              o_v_r;
  logic [stdet_pkg::PEAK_OUT_W-1:0]  o_peak_r;
  logic [stdet_pkg::FREQ_W-1:0]      o_freq_r;
  logic [stdet_pkg::CODE_W-1:0]      o_code_r;
  logic                              o_det_r;
  logic [stdet_pkg::CODE_W-1:0]      prev_r;
  logic [stdet_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [stdet_pkg::CODE_W-1:0]      code;
  logic                              e_ready, o_ready, o_load;

  assign o_ready  = !o_v_r || out_ch.ready;
  assign e_ready  = !e_v_r || o_ready;
  assign fr_ready = e_ready;
  assign o_load   = o_ready && e_v_r;

  // first matching open band wins
  always_comb begin
    logic signed [stdet_pkg::CMP_W-1:0] lo, hi, f_s;
    code = stdet_pkg::CODE_NONE;
    f_s  = $signed(stdet_pkg::CMP_W'(fr_item.freq));
    for (int k = stdet_pkg::NUM_BANDS - 1; k >= 0; k--) begin
      lo = $signed(stdet_pkg::CMP_W'({cfg.band_hz[k], 4'b0}) -
                   stdet_pkg::CMP_W'({cfg.tol_hz, 4'b0}));
      hi = $signed(stdet_pkg::CMP_W'({cfg.band_hz[k], 4'b0}) +
                   stdet_pkg::CMP_W'({cfg.tol_hz, 4'b0}));
      if (f_s > lo && f_s < hi) begin
        code = stdet_pkg::CODE_W'(k + 1);
      end
    end
  end

  // repeat count: saturating on a repeated code, cleared on a change
  always_comb begin
    if (e_code_r == prev_r) begin
      cnt_nxt = (cnt_r == stdet_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    end else begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
      prev_r <= stdet_pkg::CODE_NONE;
      cnt_r  <= '0;
    end else begin
      if (e_ready) begin
        e_v_r <= fr_valid;
      end
      if (o_ready) begin
        o_v_r <= e_v_r;
      end
      if (o_load) begin
        prev_r <= e_code_r;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (e_ready && fr_valid) begin
      e_code_r <= code;
      e_item_r <= fr_item;
    end
    if (o_load) begin
      o_peak_r <= stdet_pkg::PEAK_OUT_W'(e_item_r.peak);
      o_freq_r <= e_item_r.freq;
      o_code_r <= e_code_r;
      o_det_r  <= cnt_nxt >= cfg.thresh;
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.peak_bin     = o_peak_r;
  assign out_ch.peak_freq_q4 = o_freq_r;
  assign out_ch.tone_code    = o_code_r;
  assign out_ch.repeat_count = cnt_r;
  assign out_ch.detected     = o_det_r;

  `ASSERT_IMPL(a_code_range, e_v_r, e_code_r <= stdet_pkg::CODE_W'(stdet_pkg::NUM_BANDS), "tone code out of range")
  `ASSERT_NEXT(a_cnt_step, o_load && e_code_r == prev_r && cnt_r != stdet_pkg::CNT_MAX, cnt_r == stdet_pkg::CNT_W'($past(cnt_r) + 1'b1), "repeat count did not advance")
  `ASSERT_NEXT(a_cnt_clear, o_load && e_code_r != prev_r, cnt_r == '0 && prev_r == $past(e_code_r), "code change did not restart count")

endmodule

>>> hdl/spectral_tone_detector_top.sv
// Spectral tone detector: upper-half peak search, bin to q4 frequency, band code.
// Throughput: one bin beat per cycle while in_ch.ready is high; a frame's result follows its last bin.
// Path: once the frame_end beat is taken the result passes the peak register, three frequency
// map stages (b, c, d), the band register and the result register; each stage can stall.
// Reset: synchronous active-low; config regs return to defaults, frame state and
// persistence count clear; no memories, so no clearing pass.
module spectral_tone_detector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  stdet_in_if.sink                         in_ch,
  stdet_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [stdet_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [stdet_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [stdet_pkg::NUM_BANDS-1:0][stdet_pkg::HZ_W-1:0] band_r;
  logic [stdet_pkg::TOL_W-1:0] tol_r;
  logic [stdet_pkg::CNT_W-1:0] thresh_r;
  stdet_pkg::cfg_t             cfg;

  logic                        pk_valid, pk_ready;
  logic [stdet_pkg::BIN_W-1:0] pk_bin;
  logic                        fr_valid, fr_ready;
  stdet_pkg::freq_item_t       fr_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r[0] <= stdet_pkg::BAND_ONE_RST;
      band_r[1] <= stdet_pkg::BAND_TWO_RST;
      band_r[2] <= stdet_pkg::BAND_THREE_RST;
      band_r[3] <= stdet_pkg::BAND_FOUR_RST;
      tol_r     <= stdet_pkg::TOL_RST;
      thresh_r  <= stdet_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stdet_pkg::REG_BAND_ONE:   band_r[0] <= cfg_data[stdet_pkg::HZ_W-1:0];
        stdet_pkg::REG_BAND_TWO:   band_r[1] <= cfg_data[stdet_pkg::HZ_W-1:0];
        stdet_pkg::REG_BAND_THREE: band_r[2] <= cfg_data[stdet_pkg::HZ_W-1:0];
        stdet_pkg::REG_BAND_FOUR:  band_r[3] <= cfg_data[stdet_pkg::HZ_W-1:0];
        stdet_pkg::REG_TOLERANCE:  tol_r     <= cfg_data[stdet_pkg::TOL_W-1:0];
        stdet_pkg::REG_THRESHOLD:  thresh_r  <= cfg_data[stdet_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.band_hz = band_r;
    cfg.tol_hz  = tol_r;
    cfg.thresh  = thresh_r;
  end

  stdet_peak_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .pk_valid (pk_valid),
    .pk_ready (pk_ready),
    .pk_bin   (pk_bin)
  );

  stdet_freq_map u_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .pk_valid (pk_valid),
    .pk_ready (pk_ready),
    .pk_bin   (pk_bin),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_item  (fr_item)
  );

  stdet_tone_class u_class (
    .clk      (clk),
    .rst_n    (rst_n),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_item  (fr_item),
    .cfg      (cfg),
    .out_ch   (out_ch)
  );

endmodule
